@@ rtl/core/nllp_pkg.sv @@
// ----------------------------------------------------------------------------
// Title       : Nonlinear ladder lowpass package
// Description : Widths, register codes, the link between ladder cells and the
//               tanh point table shared by the whole ladder lowpass unit.
// ----------------------------------------------------------------------------
package nllp_pkg;

   // State format: signed Q3.FRAC in STATE_WIDTH bits.
   localparam int STATE_WIDTH     = 24;
   localparam int TANH_TABLE_BITS = 8;
   localparam int FRAC            = STATE_WIDTH - 3;

   // Widest value that goes through tanh, and the tanh result width.
   localparam int TIN_W = STATE_WIDTH + 3;
   localparam int TH_W  = FRAC + 1;

   localparam int TANH_POINTS = (1 << TANH_TABLE_BITS) + 1;
   localparam int TANH_SHIFT  = FRAC + 2 - TANH_TABLE_BITS;

   localparam int NUM_STAGES  = 4;
   localparam int FRONT_DEPTH = 5;
   localparam int SAMPLE_W    = 16;

   // Configuration registers.
   localparam int DRIVE_W     = 16;
   localparam int CUTOFF_W    = 17;
   localparam int RESO_W      = 15;
   localparam int DRIVE_FRAC  = 12;
   localparam int CUTOFF_FRAC = 16;
   localparam int RESO_FRAC   = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [DRIVE_W-1:0]  DRIVE_RESET  = 16'd4096;
   localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 17'd16384;
   localparam logic [RESO_W-1:0]   RESO_RESET   = 15'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRIVE_GAIN     = 2'd0,
      CSR_CUTOFF_COEFF   = 2'd1,
      CSR_RESONANCE_GAIN = 2'd2
   } csr_index_type;

   // Product widths of the front end and of a ladder cell.
   localparam int DRV_PROD_W  = FRAC + 1 + DRIVE_W + 1;
   localparam int FB_PROD_W   = STATE_WIDTH + RESO_W + 1;
   localparam int CELL_PROD_W = TH_W + 1 + CUTOFF_W + 1;

   // Output conversion.
   localparam int OQ_W    = STATE_WIDTH - FRAC + 15;
   localparam int OUT_MAX = 32735;
   localparam int OUT_MIN = -32768;

   // Value handed from one ladder cell to the next.
   typedef struct packed {
      logic             valid;
      logic [TIN_W-1:0] value;
   } lad_link_type;

   // tanh table: point k is tanh(4k / 2^TANH_TABLE_BITS), Q0.FRAC, built as
   // (1 - e) / (1 + e) with e = exp(-2x) from a truncated series in Q30.
   localparam longint unsigned Q30_ONE = 64'd1073741824;

   typedef longint unsigned exp_tab_type [9];
   localparam exp_tab_type EXP_NEG_INT = '{
      64'd1073741824, 64'd395007542, 64'd145315154, 64'd53458458, 64'd19666268,
      64'd7234798, 64'd2661539, 64'd979120, 64'd360201
   };

   typedef logic [FRAC-1:0] tanh_tab_type [TANH_POINTS];

   // Restoring division, only evaluated while the table is built. The divisor
   // stays far below 2^63, so the running remainder never overflows.
   function automatic longint unsigned const_udiv(longint unsigned dividend,
                                                  longint unsigned divisor);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], dividend[b]};
         if (r >= divisor) begin
            r    = r - divisor;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic tanh_tab_type build_tanh_tab();
      tanh_tab_type      tab;
      longint unsigned   u;
      longint unsigned   n;
      longint unsigned   f;
      longint unsigned   term;
      longint unsigned   e;
      longint unsigned   num;
      longint unsigned   den;
      longint            sum;
      for (int k = 0; k < TANH_POINTS; k++) begin
         u    = longint'(k) << (33 - TANH_TABLE_BITS);
         n    = u >> 30;
         f    = u & (Q30_ONE - 64'd1);
         term = Q30_ONE;
         sum  = longint'(Q30_ONE);
         if (n > 64'd8) begin
            n = 64'd8;
         end
         for (int j = 1; j <= 12; j++) begin
            term = const_udiv((term * f) >> 30, 64'(j));
            if (j[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
         end
         e      = (EXP_NEG_INT[n[3:0]] * $unsigned(sum)) >> 30;
         num    = (Q30_ONE - e) << FRAC;
         den    = Q30_ONE + e;
         tab[k] = FRAC'(const_udiv(num, den));
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh_tab();

endpackage

@@ rtl/core/nllp_tanh.sv @@
// ----------------------------------------------------------------------------
// Title       : Ladder tanh unit
// Description : Two-stage tanh by table lookup and linear interpolation. The
//               lookup results are registered, and so is the result.
// ----------------------------------------------------------------------------
module nllp_tanh (
   input  logic                       clock,
   input  logic [nllp_pkg::TIN_W-1:0] arg,
   output logic [nllp_pkg::TH_W-1:0]  result
);
   import nllp_pkg::*;

   logic                        neg;
   logic [TIN_W-1:0]            mag;
   logic                        big;
   logic [TANH_TABLE_BITS:0]    idx0;
   logic [TANH_TABLE_BITS:0]    idx1;
   logic [FRAC-1:0]             t0_in;
   logic [FRAC-1:0]             dt_in;
   logic [FRAC-1:0]             t0_ff;
   logic [FRAC-1:0]             dt_ff;
   logic [TANH_SHIFT-1:0]       fr_ff;
   logic                        neg_ff;
   logic [FRAC+TANH_SHIFT-1:0]  interp;
   logic [FRAC-1:0]             mag_out;
   logic [TH_W-1:0]             result_in;
   logic [TH_W-1:0]             result_ff;

   // Lookup stage: magnitude, table index and the two neighboring points.
   always_comb begin
      neg  = arg[TIN_W-1];
      mag  = neg ? (~arg + TIN_W'(1)) : arg;
      big  = |mag[TIN_W-1:FRAC+2];
      idx0 = {1'b0, mag[FRAC+1:TANH_SHIFT]};
      idx1 = idx0 + (TANH_TABLE_BITS+1)'(1);
      if (big) begin
         t0_in = TANH_TAB[TANH_POINTS-1];
         dt_in = '0;
      end else begin
         t0_in = TANH_TAB[idx0];
         dt_in = TANH_TAB[idx1] - TANH_TAB[idx0];
      end
   end

   // Interpolation stage.
   always_comb begin
      interp    = dt_ff * fr_ff;
      mag_out   = t0_ff + interp[FRAC+TANH_SHIFT-1:TANH_SHIFT];
      result_in = neg_ff ? (~{1'b0, mag_out} + TH_W'(1)) : {1'b0, mag_out};
   end

   always_ff @(posedge clock) begin
      t0_ff     <= t0_in;
      dt_ff     <= dt_in;
      fr_ff     <= mag[TANH_SHIFT-1:0];
      neg_ff    <= neg;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

@@ rtl/core/nllp_cell.sv @@
// ----------------------------------------------------------------------------
// Title       : Ladder cell
// Description : One integrator stage, y += g * (tanh(in) - tanh(y)) with
//               saturation. Hands the new y onward, flagged valid together with it.
// ----------------------------------------------------------------------------
module nllp_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [nllp_pkg::CUTOFF_W-1:0] cutoff,
   input  nllp_pkg::lad_link_type        link_in,
   output nllp_pkg::lad_link_type        link_out
);
   import nllp_pkg::*;

   logic [STATE_WIDTH-1:0]        y_ff;
   logic [STATE_WIDTH-1:0]        y_in;
   logic [2:0]                    vld_ff;
   logic [2:0]                    vld_in;
   logic                          done_ff;
   logic [TIN_W-1:0]              y_ext;
   logic [TH_W-1:0]               th_in;
   logic [TH_W-1:0]               th_y;
   logic [TH_W:0]                 diff;
   logic signed [CELL_PROD_W-1:0] prod_in;
   logic signed [CELL_PROD_W-1:0] prod_ff;
   logic [STATE_WIDTH+1:0]        sum;
   logic [STATE_WIDTH-1:0]        sat;

   assign y_ext = {{(TIN_W-STATE_WIDTH){y_ff[STATE_WIDTH-1]}}, y_ff};

   nllp_tanh u_tanh_in (
      .clock  (clock),
      .arg    (link_in.value),
      .result (th_in)
   );

   nllp_tanh u_tanh_y (
      .clock  (clock),
      .arg    (y_ext),
      .result (th_y)
   );

   always_comb begin
      diff    = {th_in[TH_W-1], th_in} - {th_y[TH_W-1], th_y};
      prod_in = $signed({1'b0, cutoff}) * $signed(diff);
      sum     = {{2{y_ff[STATE_WIDTH-1]}}, y_ff}
              + {prod_ff[CELL_PROD_W-1], prod_ff[CELL_PROD_W-1:CUTOFF_FRAC]};
      if (sum[STATE_WIDTH+1:STATE_WIDTH-1] == 3'b000 ||
          sum[STATE_WIDTH+1:STATE_WIDTH-1] == 3'b111) begin
         sat = sum[STATE_WIDTH-1:0];
      end else if (sum[STATE_WIDTH+1]) begin
         sat = {1'b1, {(STATE_WIDTH-1){1'b0}}};
      end else begin
         sat = {1'b0, {(STATE_WIDTH-1){1'b1}}};
      end
      y_in   = vld_ff[2] ? sat : y_ff;
      vld_in = {vld_ff[1:0], link_in.valid};
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         y_ff    <= '0;
         vld_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         y_ff    <= y_in;
         vld_ff  <= vld_in;
         done_ff <= vld_ff[2];
      end
   end

   assign link_out.valid = done_ff;
   assign link_out.value = y_ext;

endmodule

@@ rtl/core/nonlinear_ladder_lowpass_unit.sv @@
// ----------------------------------------------------------------------------
// Title       : Nonlinear ladder lowpass unit
// Description : An accepted item passes the front end, the four ladder cells and
//               the output register on its way to rsp_valid. One item is in work
//               at a time; the input reopens once the ladder is done with it. A
//               result left waiting in both slots stalls the input further.
//               Reset clears the ladder state and restores register defaults.
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [nllp_pkg::SAMPLE_W-1:0]   req_in_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [nllp_pkg::SAMPLE_W-1:0]   rsp_out_sample,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [nllp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [nllp_pkg::CSR_DATA_W-1:0]        csr_data
);
   import nllp_pkg::*;

   // Configuration registers. The user must make writes only while the unit is
   // idle; the unit has no check for it. The port is ready when out of reset.
   logic [DRIVE_W-1:0]  drive_ff;
   logic [DRIVE_W-1:0]  drive_in;
   logic [CUTOFF_W-1:0] cutoff_ff;
   logic [CUTOFF_W-1:0] cutoff_in;
   logic [RESO_W-1:0]   reso_ff;
   logic [RESO_W-1:0]   reso_in;

   assign csr_ready = ~reset;

   always_comb begin
      drive_in  = drive_ff;
      cutoff_in = cutoff_ff;
      reso_in   = reso_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DRIVE_GAIN:     drive_in  = csr_data[DRIVE_W-1:0];
            CSR_CUTOFF_COEFF:   cutoff_in = csr_data[CUTOFF_W-1:0];
            CSR_RESONANCE_GAIN: reso_in   = csr_data[RESO_W-1:0];
            default:            drive_in  = drive_ff;
         endcase
      end
   end

   // Input side. One item is in the ladder at a time; the input stalls during
   // reset, while an item is at work and while both result slots are taken.
   logic                   accept;
   logic                   busy_ff;
   logic                   busy_in;
   logic [FRONT_DEPTH-1:0] fv_ff;
   logic [FRONT_DEPTH-1:0] fv_in;
   logic                   done;
   logic                   pend_vld_ff;

   assign req_stall = reset | busy_ff | pend_vld_ff;
   assign accept    = req_valid & ~req_stall;

   // Front end. The sample is scaled to the state format and multiplied by
   // the drive gain; in parallel the mean of the last two fourth-stage values
   // is multiplied by the resonance gain. The drive product goes through tanh
   // and the feedback is subtracted, which gives the first cell's input.
   logic [SAMPLE_W-1:0]          x_ff;
   logic [STATE_WIDTH-1:0]       avg_ff;
   logic [STATE_WIDTH-1:0]       avg_in;
   logic [STATE_WIDTH:0]         pair_sum;
   logic [STATE_WIDTH-1:0]       prev_ff;
   logic [STATE_WIDTH-1:0]       stage_four;
   logic signed [FRAC:0]         x_sh;
   logic signed [DRV_PROD_W-1:0] drv_prod_in;
   logic signed [DRV_PROD_W-1:0] drv_prod_ff;
   logic signed [FB_PROD_W-1:0]  fb_prod_in;
   logic signed [FB_PROD_W-1:0]  fb_prod_ff;
   logic [TIN_W-1:0]             drv;
   logic [TIN_W-1:0]             fb;
   logic [TH_W-1:0]              cs;
   logic [TIN_W-1:0]             u_in;
   logic [TIN_W-1:0]             u_ff;

   always_comb begin
      // Floor of the mean: the sum is one bit wider, then its low bit drops.
      pair_sum    = {prev_ff[STATE_WIDTH-1], prev_ff}
                  + {stage_four[STATE_WIDTH-1], stage_four};
      avg_in      = pair_sum[STATE_WIDTH:1];
      x_sh        = (FRAC+1)'($signed(x_ff)) <<< (FRAC - 15);
      drv_prod_in = x_sh * $signed({1'b0, drive_ff});
      fb_prod_in  = $signed({1'b0, reso_ff}) * $signed(avg_ff);
      // Arithmetic right shifts are plain part-selects of the products.
      drv         = drv_prod_ff[DRV_PROD_W-1:DRIVE_FRAC];
      fb          = fb_prod_ff[FB_PROD_W-1:RESO_FRAC];
      u_in        = {{(TIN_W-TH_W){cs[TH_W-1]}}, cs} - fb;
      fv_in       = {fv_ff[FRONT_DEPTH-2:0], accept};
      busy_in     = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   nllp_tanh u_front_tanh (
      .clock  (clock),
      .arg    (drv),
      .result (cs)
   );

   // The ladder: four identical cells, each holding one stage value and
   // passing its updated value to the next cell.
   lad_link_type link [NUM_STAGES+1];

   assign link[0].valid = fv_ff[FRONT_DEPTH-1];
   assign link[0].value = u_ff;

   genvar gi;
   for (gi = 0; gi < NUM_STAGES; gi++) begin : g_cell
      nllp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cutoff   (cutoff_ff),
         .link_in  (link[gi]),
         .link_out (link[gi+1])
      );
   end

   assign done       = link[NUM_STAGES].valid;
   assign stage_four = link[NUM_STAGES].value[STATE_WIDTH-1:0];

   // Output conversion: the fourth stage is truncated toward zero to Q15 and
   // clipped to the range -1.0 .. 0.999 full scale.
   logic                  s4_neg;
   logic [STATE_WIDTH-1:0] s4_mag;
   logic [OQ_W-1:0]       q_mag;
   logic signed [OQ_W:0]  o_val;
   logic [SAMPLE_W-1:0]   res_data;

   always_comb begin
      s4_neg = stage_four[STATE_WIDTH-1];
      s4_mag = s4_neg ? (~stage_four + STATE_WIDTH'(1)) : stage_four;
      q_mag  = s4_mag[STATE_WIDTH-1:FRAC-15];
      o_val  = s4_neg ? $signed(~{1'b0, q_mag} + (OQ_W+1)'(1)) : $signed({1'b0, q_mag});
      if (o_val > (OQ_W+1)'(OUT_MAX)) begin
         res_data = SAMPLE_W'(OUT_MAX);
      end else if (o_val < (OQ_W+1)'(OUT_MIN)) begin
         res_data = SAMPLE_W'(OUT_MIN);
      end else begin
         res_data = o_val[SAMPLE_W-1:0];
      end
   end

   // Result side: an output register and one pending slot, so an item can be
   // accepted while the previous result still waits to be taken.
   logic                take;
   logic [SAMPLE_W-1:0] out_ff;
   logic [SAMPLE_W-1:0] out_in;
   logic                out_vld_ff;
   logic                out_vld_in;
   logic [SAMPLE_W-1:0] pend_ff;
   logic [SAMPLE_W-1:0] pend_in;
   logic                pend_vld_in;

   always_comb begin
      take        = out_vld_ff & ~rsp_stall;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      if (done) begin
         if (!out_vld_ff || take) begin
            out_in     = res_data;
            out_vld_in = 1'b1;
         end else begin
            pend_in     = res_data;
            pend_vld_in = 1'b1;
         end
      end else if (take) begin
         if (pend_vld_ff) begin
            out_in      = pend_ff;
            pend_vld_in = 1'b0;
         end else begin
            out_vld_in = 1'b0;
         end
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_out_sample = out_ff;

   always_ff @(posedge clock) begin
      drv_prod_ff <= drv_prod_in;
      fb_prod_ff  <= fb_prod_in;
      out_ff      <= out_in;
      pend_ff     <= pend_in;
      if (accept) begin
         x_ff   <= req_in_sample;
         avg_ff <= avg_in;
      end
      if (fv_ff[FRONT_DEPTH-2]) begin
         u_ff <= u_in;
      end
      if (reset) begin
         drive_ff    <= DRIVE_RESET;
         cutoff_ff   <= CUTOFF_RESET;
         reso_ff     <= RESO_RESET;
         busy_ff     <= 1'b0;
         fv_ff       <= '0;
         prev_ff     <= '0;
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         drive_ff    <= drive_in;
         cutoff_ff   <= cutoff_in;
         reso_ff     <= reso_in;
         busy_ff     <= busy_in;
         fv_ff       <= fv_in;
         // The current fourth stage becomes the previous one for this item.
         if (accept) begin
            prev_ff <= stage_four;
         end
         out_vld_ff  <= out_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

endmodule

@@ rtl/core/nllp_checker.sv @@
// ----------------------------------------------------------------------------
// Title       : Ladder lowpass port checker
// Description : Watches the ports of the ladder lowpass unit over time and is
//               bound to the top level.
// ----------------------------------------------------------------------------
module nllp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [nllp_pkg::SAMPLE_W-1:0] rsp_out_sample
);
   import nllp_pkg::*;

   // Items accepted whose results are not yet delivered.
   logic [1:0] owed_ff;
   logic [1:0] owed_in;
   logic       acc;
   logic       dlv;

   assign acc     = req_valid & ~req_stall;
   assign dlv     = rsp_valid & ~rsp_stall;
   assign owed_in = owed_ff + {1'b0, acc} - {1'b0, dlv};

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_sample))
      else $error("result changed while stalled");

   a_rsp_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_sample <= SAMPLE_W'(OUT_MAX))
      else $error("result above clip level");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      acc |=> req_stall)
      else $error("input not stalled after an item was taken");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != 2'd0)
      else $error("result shown with no item owed");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      owed_ff == 2'd2 |-> req_stall)
      else $error("input open with two items owed");

endmodule

bind nonlinear_ladder_lowpass_unit nllp_checker u_nllp_checker (.*);

@@ test/nonlinear_ladder_lowpass_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Title       : Nonlinear ladder lowpass unit testbench
// Description : Streams audio samples through the four-stage tanh ladder
//               under several register settings, including the extremes and
//               the saturating cutoff values. Every sample returned is
//               compared with a bit-exact fixed-point model of the ladder.
//               Both handshake sides idle in random bursts, except in the
//               final phase.
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import nllp_pkg::*;

   // Register index with no register behind it; writes to it must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Scoreboard: holds its own copy of the ladder state and the registers.
   // It predicts one output sample per accepted input item.
   class ladder_scoreboard;

      longint unsigned                tanh_points [TANH_POINTS];
      logic [DRIVE_W-1:0]             drive_gain;
      logic [CUTOFF_W-1:0]            cutoff_coeff;
      logic [RESO_W-1:0]              resonance_gain;
      logic signed [STATE_WIDTH-1:0]  stage_one;
      logic signed [STATE_WIDTH-1:0]  stage_two;
      logic signed [STATE_WIDTH-1:0]  stage_three;
      logic signed [STATE_WIDTH-1:0]  stage_four;
      logic signed [STATE_WIDTH-1:0]  stage_four_last;
      logic signed [SAMPLE_W-1:0]     predicted_out [$];
      int                             mismatches;

      // Table points are tanh(4k / 2^TANH_TABLE_BITS) = (1 - e) / (1 + e),
      // where e = exp(-2x) in Q30 comes from a whole-number factor and a
      // truncated series for the fraction.
      function new();
         longint unsigned exp_whole [9];
         longint unsigned u;
         longint unsigned n;
         longint unsigned f;
         longint unsigned term;
         longint unsigned e;
         longint unsigned num;
         longint unsigned den;
         longint          acc;
         exp_whole = '{64'd1073741824, 64'd395007542, 64'd145315154, 64'd53458458,
                       64'd19666268, 64'd7234798, 64'd2661539, 64'd979120, 64'd360201};
         for (int k = 0; k < TANH_POINTS; k++) begin
            u    = 64'(k) << (33 - TANH_TABLE_BITS);
            n    = u >> 30;
            f    = u & (64'd1073741823);
            term = 64'd1073741824;
            acc  = 64'sd1073741824;
            if (n > 64'd8) begin
               n = 64'd8;
            end
            for (int j = 1; j <= 12; j++) begin
               term = ((term * f) >> 30) / 64'(j);
               if (j % 2 == 1) begin
                  acc = acc - longint'(term);
               end else begin
                  acc = acc + longint'(term);
               end
            end
            if (acc < 0) begin
               acc = 0;
            end
            if (acc > 64'sd1073741824) begin
               acc = 64'sd1073741824;
            end
            e              = (exp_whole[n] * longint'(acc)) >> 30;
            num            = (64'd1073741824 - e) << FRAC;
            den            = 64'd1073741824 + e;
            tanh_points[k] = num / den;
         end
         drive_gain      = DRIVE_RESET;
         cutoff_coeff    = CUTOFF_RESET;
         resonance_gain  = RESO_RESET;
         stage_one       = '0;
         stage_two       = '0;
         stage_three     = '0;
         stage_four      = '0;
         stage_four_last = '0;
         mismatches      = 0;
      endfunction

      function void apply_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_DRIVE_GAIN:     drive_gain     = data[DRIVE_W-1:0];
            CSR_CUTOFF_COEFF:   cutoff_coeff   = data[CUTOFF_W-1:0];
            CSR_RESONANCE_GAIN: resonance_gain = data[RESO_W-1:0];
            default: ;
         endcase
      endfunction

      // Interpolated tanh; beyond the table it holds the last point.
      function longint tanh_interp(longint x);
         longint unsigned mag;
         longint unsigned idx;
         longint unsigned fr;
         longint unsigned r;
         mag = (x < 0) ? longint'(-x) : longint'(x);
         if (mag >= (64'd4 << FRAC)) begin
            r = tanh_points[TANH_POINTS-1];
         end else begin
            idx = (mag >> TANH_SHIFT) & ((64'd1 << TANH_TABLE_BITS) - 64'd1);
            fr  = mag & ((64'd1 << TANH_SHIFT) - 64'd1);
            r   = tanh_points[idx] +
                  (((tanh_points[idx+1] - tanh_points[idx]) * fr) >> TANH_SHIFT);
         end
         return (x < 0) ? -longint'(r) : longint'(r);
      endfunction

      // One ladder cell: y += g * (tanh(prev) - tanh(y)), saturated to the state range.
      function longint ladder_cell(longint y, longint drive_in);
         longint d;
         longint v;
         longint hi;
         d  = drive_in - tanh_interp(y);
         v  = y + ((longint'(cutoff_coeff) * d) >>> CUTOFF_FRAC);
         hi = (longint'(1) << (STATE_WIDTH - 1)) - 1;
         if (v > hi) begin
            v = hi;
         end else if (v < -hi - 1) begin
            v = -hi - 1;
         end
         return v;
      endfunction

      function logic signed [SAMPLE_W-1:0] ladder_step(logic signed [SAMPLE_W-1:0] sample);
         longint          x;
         longint          avg;
         longint          fb;
         longint          o;
         longint unsigned mag;
         x   = sample;
         x   = x * (longint'(1) << (FRAC - 15));
         x   = tanh_interp((x * longint'(drive_gain)) >>> DRIVE_FRAC);
         avg = (longint'(stage_four_last) + longint'(stage_four)) >>> 1;
         fb  = (longint'(resonance_gain) * avg) >>> RESO_FRAC;
         stage_one       = ladder_cell(stage_one, tanh_interp(x - fb));
         stage_two       = ladder_cell(stage_two, tanh_interp(stage_one));
         stage_three     = ladder_cell(stage_three, tanh_interp(stage_two));
         stage_four_last = stage_four;
         stage_four      = ladder_cell(stage_four, tanh_interp(stage_three));
         mag = (stage_four < 0) ? longint'(-longint'(stage_four)) : longint'(stage_four);
         o   = longint'(mag >> (FRAC - 15));
         if (stage_four < 0) begin
            o = -o;
         end
         if (o < OUT_MIN) begin
            o = OUT_MIN;
         end
         if (o > OUT_MAX) begin
            o = OUT_MAX;
         end
         return o[SAMPLE_W-1:0];
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] sample);
         predicted_out.push_back(ladder_step(sample));
      endfunction

      function void check_sample(logic signed [SAMPLE_W-1:0] got);
         logic signed [SAMPLE_W-1:0] want;
         if (predicted_out.size() == 0) begin
            $error("out_sample arrived with no item outstanding: expected none, actual %0d",
                   got);
            mismatches++;
         end else begin
            want = predicted_out.pop_front();
            if (got !== want) begin
               $error("out_sample mismatch: expected %0d, actual %0d", want, got);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return predicted_out.size();
      endfunction

   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_W-1:0]    req_in_sample;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_W-1:0]    rsp_out_sample;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;

   ladder_scoreboard sb;

   // Idling switches for the two sides; both are cleared for the final phase.
   bit req_idle_on;
   bit rsp_idle_on;

   nonlinear_ladder_lowpass_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run. It leaves a wide margin over the slowest legal run.
   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: while idling is on, stall in random bursts. A pass through
   // the loop sets rsp_stall for a burst and then clears it, or only clears it.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // A result item is taken at an edge where rsp_valid is high and rsp_stall
   // is low. Values read here are the ones that held before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_sample(rsp_out_sample);
      end
   end

   // Presents one sample and holds it until the block takes it. The model is
   // advanced at the accepting edge. Afterwards the sender may go idle for a
   // burst. When no idle follows, req_valid stays high for the next item.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
      req_valid     <= 1'b1;
      req_in_sample <= sample;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_sample(sample);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every predicted sample has come back, so
   // the block is idle before registers change.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers back to back, then the unused index if asked.
   // csr_valid stays high between writes and drops after the last one.
   task automatic program_filter(input logic [CSR_DATA_W-1:0] drive,
                                 input logic [CSR_DATA_W-1:0] cutoff,
                                 input logic [CSR_DATA_W-1:0] reso,
                                 input bit                    touch_unused);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  val [4];
      int                     count;
      idx   = '{CSR_DRIVE_GAIN, CSR_CUTOFF_COEFF, CSR_RESONANCE_GAIN, CSR_UNUSED};
      val   = '{drive, cutoff, reso, CSR_DATA_W'($urandom)};
      count = touch_unused ? 4 : 3;
      for (int i = 0; i < count; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do begin
            @(posedge clock);
         end while (!csr_ready);
         sb.apply_register(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] level;
      logic [CSR_DATA_W-1:0]      drive;
      logic [CSR_DATA_W-1:0]      cutoff;
      logic [CSR_DATA_W-1:0]      reso;
      int                         hold;

      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_sample = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      hold          = 0;
      level         = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. First the reset settings with full-scale steps both
      // ways and the smallest nonzero samples.
      send_sample(16'sd0);
      repeat (3) send_sample(16'sd32767);
      repeat (3) send_sample(-16'sd32768);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      drain();

      // Every register at its top. The drive value carries a bit above the
      // register's width, so it must be masked. A cutoff near 2.0 lets the
      // stages overshoot, so the state saturates and the output clips at both
      // ends. Full-scale input under that drive is far beyond the tanh table.
      program_filter(17'h1FFFF, 17'h1FFFF, 17'h07FFF, 1'b1);
      repeat (4) send_sample(16'sd32767);
      repeat (4) send_sample(-16'sd32768);
      drain();

      // Every register at zero: the ladder holds its state.
      program_filter(17'h00000, 17'h00000, 17'h00000, 1'b1);
      send_sample(16'sd21845);
      send_sample(-16'sd21846);
      send_sample(16'sd0);
      drain();

      // Unity cutoff and unity resonance.
      program_filter(17'd4096, 17'd65536, 17'd8192, 1'b0);
      repeat (3) send_sample(16'sd32767);
      send_sample(-16'sd32768);
      drain();

      // Random part. There are six phases with their own settings, and the
      // last phase runs with no idling on either side. Samples mix held
      // levels, which push the ladder toward its rails, with noise and
      // full-scale spikes.
      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 3))
            0:       drive = 17'd0;
            1:       drive = 17'h1FFFF;
            2:       drive = 17'd4096;
            default: drive = CSR_DATA_W'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0:       cutoff = 17'd0;
            1:       cutoff = 17'd65536;
            2:       cutoff = 17'h1FFFF;
            3:       cutoff = CSR_DATA_W'($urandom);
            default: cutoff = CSR_DATA_W'($urandom_range(256, 65536));
         endcase
         case ($urandom_range(0, 4))
            0:       reso = 17'd0;
            1:       reso = 17'h07FFF;
            2:       reso = CSR_DATA_W'($urandom);
            default: reso = CSR_DATA_W'($urandom_range(0, 16384));
         endcase
         program_filter(drive, cutoff, reso, $urandom_range(0, 1) == 1);

         req_idle_on = (phase != 5);
         rsp_idle_on = (phase != 5);

         for (int i = 0; i < 100; i++) begin
            if (hold == 0 && $urandom_range(0, 15) == 0) begin
               hold = $urandom_range(5, 30);
               case ($urandom_range(0, 2))
                  0:       level = 16'sd32767;
                  1:       level = -16'sd32768;
                  default: level = SAMPLE_W'($urandom);
               endcase
            end
            if (hold > 0) begin
               sample = level;
               hold--;
            end else begin
               case ($urandom_range(0, 9))
                  0:       sample = 16'sd32767;
                  1:       sample = -16'sd32768;
                  2, 3:    sample = SAMPLE_W'($urandom_range(0, 511) - 256);
                  default: sample = SAMPLE_W'($urandom);
               endcase
            end
            send_sample(sample);

            // Once, the sender waits in mid-stream until the block has
            // returned every outstanding item.
            if (phase == 2 && i == 50) begin
               drain();
            end
         end
         drain();
      end

      // Every expected sample is back. Allow more than one block latency in
      // case a stray item is still on its way out.
      repeat (30) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/nllp_pkg.sv
rtl/core/nllp_tanh.sv
rtl/core/nllp_cell.sv
rtl/core/nonlinear_ladder_lowpass_unit.sv
rtl/core/nllp_checker.sv
test/nonlinear_ladder_lowpass_unit_tb.sv
